// ===== rtl/slew_limited_pid_position_loop_top_defines.svh =====
`ifndef SLEW_LIMITED_PID_POSITION_LOOP_TOP_DEFINES_SVH
`define SLEW_LIMITED_PID_POSITION_LOOP_TOP_DEFINES_SVH

// Check that a condition holds at every clock edge outside reset.
`define SLPID_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a consequent holds whenever an antecedent does.
`define SLPID_ASSERT_IMPLY(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// ===== rtl/slpid_pkg.sv =====
package slpid_pkg;

    localparam int POS_MIN_DEF     = 0;
    localparam int POS_MAX_DEF     = 200000;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int VEL_HOLD        = 5000;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [1:0] OP_GOAL = 2'd0;
    localparam logic [1:0] OP_MEAS = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [2:0] REG_PROP_GAIN      = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN     = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN     = 3'd2;
    localparam logic [2:0] REG_HOLD_FORCE     = 3'd3;
    localparam logic [2:0] REG_EFFORT_LIMIT   = 3'd4;
    localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd5;
    localparam logic [2:0] REG_SLEW_STEP      = 3'd6;
    localparam logic [2:0] REG_HOLD_BAND      = 3'd7;

    localparam logic [23:0] PROP_GAIN_RST      = 24'd629;
    localparam logic [23:0] INTEG_GAIN_RST     = 24'd0;
    localparam logic [23:0] DERIV_GAIN_RST     = 24'd315;
    localparam logic [18:0] HOLD_FORCE_RST     = 19'd5886;
    localparam logic [18:0] EFFORT_LIMIT_RST   = 19'd500000;
    localparam logic [30:0] INTEGRAL_LIMIT_RST = 31'h7FFF_FFFF;
    localparam logic [17:0] SLEW_STEP_RST      = 18'd10000;
    localparam logic [17:0] HOLD_BAND_RST      = 18'd1000;

    typedef enum logic [1:0] {
        CMD_GOAL,
        CMD_MEAS,
        CMD_TICK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic signed [18:0] pos;
        logic signed [20:0] vel;
    } cmd_t;

    typedef struct packed {
        logic [23:0] prop_gain;
        logic [23:0] integ_gain;
        logic [23:0] deriv_gain;
        logic [18:0] hold_force;
        logic [18:0] effort_limit;
        logic [30:0] integral_limit;
        logic [17:0] slew_step;
        logic [17:0] hold_band;
    } cfg_t;

endpackage

// ===== rtl/slpid_if.sv =====
interface slpid_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [18:0] goal_position;
    logic signed [18:0] measured_position;
    logic signed [20:0] measured_velocity;

    modport source (
        output valid, operation, goal_position, measured_position, measured_velocity,
        input  ready
    );
    modport sink (
        input  valid, operation, goal_position, measured_position, measured_velocity,
        output ready
    );
endinterface

interface slpid_out_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] effort;
    logic               holding;
    logic               saturated;

    modport source (
        output valid, effort, holding, saturated,
        input  ready
    );
    modport sink (
        input  valid, effort, holding, saturated,
        output ready
    );
endinterface

// ===== rtl/slpid_regs.sv =====
module slpid_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [slpid_pkg::ADDR_W-1:0] paddr,
    input  logic [slpid_pkg::DATA_W-1:0] pwdata,
    output logic [slpid_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output slpid_pkg::cfg_t             cfg
);

    slpid_pkg::cfg_t cfg_reg;
    logic            wr_en;
    logic [2:0]      idx;

    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain      <= slpid_pkg::PROP_GAIN_RST;
            cfg_reg.integ_gain     <= slpid_pkg::INTEG_GAIN_RST;
            cfg_reg.deriv_gain     <= slpid_pkg::DERIV_GAIN_RST;
            cfg_reg.hold_force     <= slpid_pkg::HOLD_FORCE_RST;
            cfg_reg.effort_limit   <= slpid_pkg::EFFORT_LIMIT_RST;
            cfg_reg.integral_limit <= slpid_pkg::INTEGRAL_LIMIT_RST;
            cfg_reg.slew_step      <= slpid_pkg::SLEW_STEP_RST;
            cfg_reg.hold_band      <= slpid_pkg::HOLD_BAND_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                slpid_pkg::REG_PROP_GAIN:      cfg_reg.prop_gain      <= pwdata[23:0];
                slpid_pkg::REG_INTEG_GAIN:     cfg_reg.integ_gain     <= pwdata[23:0];
                slpid_pkg::REG_DERIV_GAIN:     cfg_reg.deriv_gain     <= pwdata[23:0];
                slpid_pkg::REG_HOLD_FORCE:     cfg_reg.hold_force     <= pwdata[18:0];
                slpid_pkg::REG_EFFORT_LIMIT:   cfg_reg.effort_limit   <= pwdata[18:0];
                slpid_pkg::REG_INTEGRAL_LIMIT: cfg_reg.integral_limit <= pwdata[30:0];
                slpid_pkg::REG_SLEW_STEP:      cfg_reg.slew_step      <= pwdata[17:0];
                slpid_pkg::REG_HOLD_BAND:      cfg_reg.hold_band      <= pwdata[17:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            slpid_pkg::REG_PROP_GAIN:      prdata = {8'b0, cfg_reg.prop_gain};
            slpid_pkg::REG_INTEG_GAIN:     prdata = {8'b0, cfg_reg.integ_gain};
            slpid_pkg::REG_DERIV_GAIN:     prdata = {8'b0, cfg_reg.deriv_gain};
            slpid_pkg::REG_HOLD_FORCE:     prdata = {13'b0, cfg_reg.hold_force};
            slpid_pkg::REG_EFFORT_LIMIT:   prdata = {13'b0, cfg_reg.effort_limit};
            slpid_pkg::REG_INTEGRAL_LIMIT: prdata = {1'b0, cfg_reg.integral_limit};
            slpid_pkg::REG_SLEW_STEP:      prdata = {14'b0, cfg_reg.slew_step};
            slpid_pkg::REG_HOLD_BAND:      prdata = {14'b0, cfg_reg.hold_band};
            default:                       prdata = '0;
        endcase
    end

endmodule

// ===== rtl/slpid_front.sv =====
module slpid_front #(
    parameter int POS_MIN = slpid_pkg::POS_MIN_DEF,
    parameter int POS_MAX = slpid_pkg::POS_MAX_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    slpid_in_if.sink        in_item,
    input  logic            full,
    output logic            push,
    output slpid_pkg::cmd_t push_cmd
);

    localparam logic signed [18:0] POS_MIN_S = 19'(POS_MIN);
    localparam logic signed [18:0] POS_MAX_S = 19'(POS_MAX);

    logic               seen_reg;
    logic               accept;
    logic               keep;
    logic signed [18:0] goal_clamped;

    assign in_item.ready = !full;
    assign accept        = in_item.valid && !full;
    assign push          = accept && keep;

    always_comb
    begin
        if (in_item.goal_position < POS_MIN_S)
            goal_clamped = POS_MIN_S;
        else if (in_item.goal_position > POS_MAX_S)
            goal_clamped = POS_MAX_S;
        else
            goal_clamped = in_item.goal_position;
    end

    // drop unused codes and ticks that arrive before any measurement
    always_comb
    begin
        push_cmd.vel = in_item.measured_velocity;
        case (in_item.operation)
            slpid_pkg::OP_GOAL:
            begin
                keep          = 1'b1;
                push_cmd.kind = slpid_pkg::CMD_GOAL;
                push_cmd.pos  = goal_clamped;
            end
            slpid_pkg::OP_MEAS:
            begin
                keep          = 1'b1;
                push_cmd.kind = slpid_pkg::CMD_MEAS;
                push_cmd.pos  = in_item.measured_position;
            end
            slpid_pkg::OP_TICK:
            begin
                keep          = seen_reg;
                push_cmd.kind = slpid_pkg::CMD_TICK;
                push_cmd.pos  = in_item.measured_position;
            end
            default:
            begin
                keep          = 1'b0;
                push_cmd.kind = slpid_pkg::CMD_TICK;
                push_cmd.pos  = in_item.measured_position;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= 1'b0;
        else if (accept && in_item.operation == slpid_pkg::OP_MEAS)
            seen_reg <= 1'b1;
    end

endmodule

// ===== rtl/slpid_queue.sv =====
module slpid_queue #(
    parameter int DEPTH = slpid_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  slpid_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output slpid_pkg::cmd_t head
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    slpid_pkg::cmd_t  mem_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + IDX_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== rtl/slpid_back.sv =====
`include "slew_limited_pid_position_loop_top_defines.svh"

module slpid_back #(
    parameter int POS_MIN = slpid_pkg::POS_MIN_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  slpid_pkg::cfg_t cfg,
    input  logic            head_valid,
    input  slpid_pkg::cmd_t head,
    output logic            pop,
    slpid_out_if.source     out_item
);

    localparam logic [17:0] POS_MIN_U = 18'(POS_MIN);

    logic               en;

    logic [17:0]        ramp_reg;
    logic [17:0]        goal_reg;
    logic signed [18:0] pos_reg;
    logic signed [20:0] vel_reg;
    logic signed [31:0] acc_reg;

    logic signed [18:0] diff;
    logic [18:0]        diff_abs;
    logic [17:0]        ramp_next;
    logic signed [19:0] err;
    logic signed [19:0] gerr;
    logic [19:0]        err_abs;
    logic [19:0]        gerr_abs;
    logic [20:0]        vel_abs;
    logic               in_band;
    logic signed [32:0] acc_sum;
    logic signed [32:0] ilim;
    logic signed [31:0] acc_next;

    logic               s2_valid_reg;
    logic               s2_hold_reg;
    logic signed [19:0] s2_err_reg;
    logic signed [31:0] s2_acc_reg;
    logic signed [20:0] s2_vel_reg;

    logic               s3_valid_reg;
    logic               s3_hold_reg;
    logic signed [44:0] s3_p_reg;
    logic signed [56:0] s3_i_reg;
    logic signed [45:0] s3_d_reg;

    logic               s4_valid_reg;
    logic               s4_hold_reg;
    logic signed [57:0] s4_sum_reg;
    logic signed [57:0] sum_next;

    logic signed [41:0] eff_raw;
    logic signed [41:0] lim_wide;
    logic signed [19:0] lim_pos;
    logic signed [19:0] lim_neg;
    logic signed [19:0] eff_next;
    logic               sat_next;

    logic               out_valid_reg;
    logic signed [19:0] effort_reg;
    logic               holding_reg;
    logic               saturated_reg;

    assign en  = !out_valid_reg || out_item.ready;
    assign pop = en && head_valid;

    assign out_item.valid     = out_valid_reg;
    assign out_item.effort    = effort_reg;
    assign out_item.holding   = holding_reg;
    assign out_item.saturated = saturated_reg;

    // slew, error, deadband and integral update
    always_comb
    begin
        diff     = $signed({1'b0, goal_reg}) - $signed({1'b0, ramp_reg});
        diff_abs = diff[18] ? 19'(-diff) : 19'(diff);
        if (diff_abs <= {1'b0, cfg.slew_step})
            ramp_next = goal_reg;
        else if (diff[18])
            ramp_next = ramp_reg - cfg.slew_step;
        else
            ramp_next = ramp_reg + cfg.slew_step;

        err      = $signed({2'b00, ramp_next}) - $signed({pos_reg[18], pos_reg});
        gerr     = $signed({2'b00, goal_reg}) - $signed({pos_reg[18], pos_reg});
        err_abs  = err[19] ? 20'(-err) : 20'(err);
        gerr_abs = gerr[19] ? 20'(-gerr) : 20'(gerr);
        vel_abs  = vel_reg[20] ? 21'(-vel_reg) : 21'(vel_reg);
        in_band  = (err_abs < {2'b00, cfg.hold_band}) &&
                   (gerr_abs < {2'b00, cfg.hold_band}) &&
                   (vel_abs < 21'(slpid_pkg::VEL_HOLD));

        acc_sum = $signed({acc_reg[31], acc_reg}) + $signed({{13{err[19]}}, err});
        ilim    = $signed({2'b00, cfg.integral_limit});
        if (in_band)
            acc_next = '0;
        else if (acc_sum > ilim)
            acc_next = ilim[31:0];
        else if (acc_sum < -ilim)
            acc_next = 32'(-ilim);
        else
            acc_next = acc_sum[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_reg <= POS_MIN_U;
            goal_reg <= POS_MIN_U;
            pos_reg  <= '0;
            vel_reg  <= '0;
            acc_reg  <= '0;
        end
        else if (pop)
        begin
            case (head.kind)
                slpid_pkg::CMD_GOAL:
                begin
                    goal_reg <= head.pos[17:0];
                    acc_reg  <= '0;
                end
                slpid_pkg::CMD_MEAS:
                begin
                    pos_reg <= head.pos;
                    vel_reg <= head.vel;
                end
                slpid_pkg::CMD_TICK:
                begin
                    ramp_reg <= ramp_next;
                    acc_reg  <= acc_next;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg  <= pop && head.kind == slpid_pkg::CMD_TICK;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    assign sum_next = s3_i_reg
                    + $signed({{13{s3_p_reg[44]}}, s3_p_reg})
                    - $signed({{12{s3_d_reg[45]}}, s3_d_reg})
                    + $signed({23'b0, cfg.hold_force, 16'b0})
                    + 58'sd32768;

    // round to nearest, then saturate
    always_comb
    begin
        eff_raw  = s4_sum_reg[57:16];
        lim_wide = $signed({23'b0, cfg.effort_limit});
        lim_pos  = $signed({1'b0, cfg.effort_limit});
        lim_neg  = -lim_pos;
        if (s4_hold_reg)
        begin
            sat_next = cfg.hold_force > cfg.effort_limit;
            eff_next = sat_next ? lim_pos : $signed({1'b0, cfg.hold_force});
        end
        else if (eff_raw > lim_wide)
        begin
            sat_next = 1'b1;
            eff_next = lim_pos;
        end
        else if (eff_raw < -lim_wide)
        begin
            sat_next = 1'b1;
            eff_next = lim_neg;
        end
        else
        begin
            sat_next = 1'b0;
            eff_next = eff_raw[19:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_hold_reg   <= in_band;
            s2_err_reg    <= err;
            s2_acc_reg    <= acc_next;
            s2_vel_reg    <= vel_reg;

            s3_hold_reg   <= s2_hold_reg;
            s3_p_reg      <= $signed({1'b0, cfg.prop_gain}) * s2_err_reg;
            s3_i_reg      <= $signed({1'b0, cfg.integ_gain}) * s2_acc_reg;
            s3_d_reg      <= $signed({1'b0, cfg.deriv_gain}) * s2_vel_reg;

            s4_hold_reg   <= s3_hold_reg;
            s4_sum_reg    <= sum_next;

            effort_reg    <= eff_next;
            holding_reg   <= s4_hold_reg;
            saturated_reg <= sat_next;
        end
    end

    `SLPID_ASSERT(a_effort_in_range, !out_valid_reg || (effort_reg <= lim_pos && effort_reg >= lim_neg), "effort outside limit")
    `SLPID_ASSERT_IMPLY(a_hold_sat, out_valid_reg && holding_reg, saturated_reg == (cfg.hold_force > cfg.effort_limit), "hold saturation mismatch")
    `SLPID_ASSERT_IMPLY(a_sat_at_limit, out_valid_reg && saturated_reg, effort_reg == lim_pos || effort_reg == lim_neg, "saturated effort not at limit")

endmodule

// ===== rtl/slew_limited_pid_position_loop_top.sv =====
// Slew-limited PID position loop with gravity feedforward. Goal, measurement and
// tick items are accepted one per clock cycle while the queue has room; a
// four-entry command queue sits between the input classifier and the execution
// pipeline, so either side can stall alone. Ticks before the first measurement and
// unused operation codes are dropped at the input. A tick result passes from the
// queue through registered state update, multiply, sum, and round and saturate
// stages. The sustained rate of one item per cycle, while the output is not
// stalled, is set by the state update, where slew, error, deadband check and
// integral clamp finish before the next item. APB registers sit at byte offsets 4*i;
// the user must write them only while no item is in flight; this is not enforced.
module slew_limited_pid_position_loop_top #(
    parameter int POS_MIN     = slpid_pkg::POS_MIN_DEF,
    parameter int POS_MAX     = slpid_pkg::POS_MAX_DEF,
    parameter int QUEUE_DEPTH = slpid_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    slpid_in_if.sink                     in_item,
    slpid_out_if.source                  out_item,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [slpid_pkg::ADDR_W-1:0] paddr,
    input  logic [slpid_pkg::DATA_W-1:0] pwdata,
    output logic [slpid_pkg::DATA_W-1:0] prdata,
    output logic                         pready
);

    slpid_pkg::cfg_t cfg;
    slpid_pkg::cmd_t push_cmd;
    slpid_pkg::cmd_t head;
    logic            push;
    logic            full;
    logic            pop;
    logic            head_valid;

    slpid_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    slpid_front #(
        .POS_MIN (POS_MIN),
        .POS_MAX (POS_MAX)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .full     (full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    slpid_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    slpid_back #(
        .POS_MIN (POS_MIN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_item   (out_item)
    );

endmodule
